FILE: src/psf_pkg.sv
// Package for the phase-angle thyristor firing controller.
// Holds field widths, step and register codes, the power-to-delay table and shared structs.
// No dependencies.
`timescale 1ns / 1ps

package psf_pkg;

  localparam int PSF_TABLE_ENTRIES = 60;
  localparam int PSF_TABLE_SLOTS   = 64;

  localparam int PSF_MODE_W   = 2;
  localparam int PSF_MEAS_W   = 18;
  localparam int PSF_DELAY_W  = 14;
  localparam int PSF_WATTS_W  = 11;
  localparam int PSF_PULSE_W  = 10;
  localparam int PSF_REQ_W    = 20;
  localparam int PSF_CFG_IDX_W  = 3;
  localparam int PSF_CFG_DATA_W = 18;

  localparam logic [PSF_DELAY_W-1:0] PSF_NO_FIRE_US  = 14'd10000;
  localparam logic [PSF_DELAY_W-1:0] PSF_MAX_FIRE_US = 14'd8400;

  typedef enum logic [PSF_MODE_W-1:0] {
    PSF_MODE_TICK   = 2'd0,
    PSF_MODE_ZC     = 2'd1,
    PSF_MODE_UPDATE = 2'd2
  } psf_mode_e;

  localparam logic [PSF_CFG_IDX_W-1:0] PSF_CFG_CONTROL_MODE = 3'd0;
  localparam logic [PSF_CFG_IDX_W-1:0] PSF_CFG_POWER_OFFSET = 3'd1;
  localparam logic [PSF_CFG_IDX_W-1:0] PSF_CFG_MANUAL_POWER = 3'd2;
  localparam logic [PSF_CFG_IDX_W-1:0] PSF_CFG_MIN_PANEL    = 3'd3;
  localparam logic [PSF_CFG_IDX_W-1:0] PSF_CFG_PULSE_WIDTH  = 3'd4;

  localparam logic [PSF_WATTS_W-1:0] PSF_WATTS [PSF_TABLE_SLOTS] = '{
    11'd38,   11'd55,   11'd75,   11'd87,   11'd100,  11'd112,  11'd125,  11'd136,
    11'd150,  11'd168,  11'd175,  11'd187,  11'd200,  11'd215,  11'd225,  11'd240,
    11'd250,  11'd263,  11'd275,  11'd288,  11'd300,  11'd313,  11'd325,  11'd338,
    11'd350,  11'd362,  11'd375,  11'd387,  11'd400,  11'd412,  11'd425,  11'd437,
    11'd450,  11'd462,  11'd475,  11'd500,  11'd525,  11'd550,  11'd575,  11'd600,
    11'd625,  11'd650,  11'd675,  11'd700,  11'd750,  11'd800,  11'd850,  11'd900,
    11'd950,  11'd1000, 11'd1050, 11'd1100, 11'd1150, 11'd1200, 11'd1250, 11'd1300,
    11'd1350, 11'd1400, 11'd1450, 11'd1500, 11'd1500, 11'd1500, 11'd1500, 11'd1500
  };

  localparam logic [PSF_DELAY_W-1:0] PSF_DELAYS [PSF_TABLE_SLOTS] = '{
    14'd8400, 14'd8188, 14'd7980, 14'd7872, 14'd7760, 14'd7674, 14'd7575, 14'd7500,
    14'd7410, 14'd7300, 14'd7260, 14'd7190, 14'd7120, 14'd7040, 14'd6990, 14'd6915,
    14'd6865, 14'd6805, 14'd6748, 14'd6690, 14'd6637, 14'd6581, 14'd6530, 14'd6475,
    14'd6425, 14'd6375, 14'd6325, 14'd6275, 14'd6225, 14'd6178, 14'd6130, 14'd6083,
    14'd6035, 14'd5990, 14'd5945, 14'd5853, 14'd5765, 14'd5678, 14'd5590, 14'd5505,
    14'd5420, 14'd5335, 14'd5250, 14'd5167, 14'd4999, 14'd4833, 14'd4665, 14'd4495,
    14'd4323, 14'd4145, 14'd3965, 14'd3775, 14'd3575, 14'd3365, 14'd3135, 14'd2880,
    14'd2590, 14'd2240, 14'd1755, 14'd350,  14'd350,  14'd350,  14'd350,  14'd350
  };

  typedef struct packed {
    logic                      control_mode;
    logic [PSF_WATTS_W-1:0]    power_offset_w;
    logic [PSF_WATTS_W-1:0]    manual_power_w;
    logic [PSF_MEAS_W-1:0]     min_panel_power_dw;
    logic [PSF_PULSE_W-1:0]    pulse_width_us;
  } psf_cfg_t;

  typedef struct packed {
    logic                   gate;
    logic [PSF_DELAY_W-1:0] delay_us;
    logic                   timer_running;
  } psf_res_t;

endpackage

FILE: src/psf_if.sv
// Handshake interfaces for the firing controller: input words, result words, register writes.
// Depends on psf_pkg for field widths.
`timescale 1ns / 1ps

interface psf_in_if import psf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PSF_MODE_W-1:0] mode;
  logic [PSF_MEAS_W-1:0] measured_power_dw;

  modport source (output valid, mode, measured_power_dw, input ready);
  modport sink   (input valid, mode, measured_power_dw, output ready);
endinterface

interface psf_out_if import psf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   gate;
  logic [PSF_DELAY_W-1:0] delay_us;
  logic                   timer_running;

  modport source (output valid, gate, delay_us, timer_running, input ready);
  modport sink   (input valid, gate, delay_us, timer_running, output ready);
endinterface

interface psf_cfg_if import psf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [PSF_CFG_IDX_W-1:0]  index;
  logic [PSF_CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/psf_lookup.sv
// Requested-power calculation and power-to-delay table search.
// Depends on psf_pkg for the table and the configuration struct.
`timescale 1ns / 1ps

module psf_lookup import psf_pkg::*; #(
  parameter int TableEntries = PSF_TABLE_ENTRIES
) (
  input  psf_cfg_t               cfg_i,
  input  logic [PSF_MEAS_W-1:0]  meas_i,
  output logic [PSF_DELAY_W-1:0] delay_o
);

  logic signed [PSF_REQ_W-1:0] offset_dw;
  logic signed [PSF_REQ_W-1:0] auto_req;
  logic signed [PSF_REQ_W-1:0] manual_req;
  logic signed [PSF_REQ_W-1:0] request;
  logic                        inhibit;
  logic [PSF_DELAY_W-1:0]      table_delay;

  assign offset_dw  = $signed({{(PSF_REQ_W-PSF_WATTS_W){cfg_i.power_offset_w[PSF_WATTS_W-1]}},
                               cfg_i.power_offset_w}) * $signed(20'sd10);
  assign auto_req   = offset_dw + $signed({{(PSF_REQ_W-PSF_MEAS_W){1'b0}}, meas_i});
  assign manual_req = $signed({{(PSF_REQ_W-PSF_WATTS_W){1'b0}}, cfg_i.manual_power_w})
                      * $signed(20'sd10);

  assign request = cfg_i.control_mode ? manual_req : auto_req;
  assign inhibit = cfg_i.control_mode ? (cfg_i.manual_power_w == '0)
                                      : (meas_i < cfg_i.min_panel_power_dw);

  // Priority search: the first entry whose power covers the request wins.
  always_comb begin
    logic                   found;
    logic [PSF_DELAY_W-1:0] watts_dw;
    found       = 1'b0;
    watts_dw    = '0;
    table_delay = PSF_DELAYS[0];
    for (int i = 0; i < TableEntries; i++) begin
      watts_dw = PSF_DELAY_W'(PSF_WATTS[i] * 10);
      if (!found && (request <= $signed({{(PSF_REQ_W-PSF_DELAY_W){1'b0}}, watts_dw}))) begin
        found       = 1'b1;
        table_delay = PSF_DELAYS[i];
      end
    end
  end

  assign delay_o = inhibit ? PSF_NO_FIRE_US : table_delay;

endmodule

FILE: src/psf_state.sv
// Firing state: delay register, zero-crossing countdown and gate pulse counter.
// Depends on psf_pkg; takes the new delay from psf_lookup.
`timescale 1ns / 1ps

module psf_state import psf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [PSF_MODE_W-1:0]  mode_i,
  input  logic [PSF_DELAY_W-1:0] new_delay_i,
  input  logic [PSF_PULSE_W-1:0] pulse_width_i,
  output psf_res_t               res_o
);

  logic [PSF_DELAY_W-1:0] delay_q, delay_d;
  logic [PSF_DELAY_W-1:0] count_q, count_d;
  logic                   armed_q, armed_d;
  logic [PSF_PULSE_W-1:0] pulse_q, pulse_d;
  logic [PSF_DELAY_W-1:0] count_dec;

  assign count_dec = (count_q != '0) ? count_q - 1'b1 : count_q;

  always_comb begin
    delay_d = delay_q;
    count_d = count_q;
    armed_d = armed_q;
    pulse_d = pulse_q;
    if (step_i) begin
      case (mode_i)
        PSF_MODE_TICK: begin
          if (pulse_q != '0) pulse_d = pulse_q - 1'b1;
          if (armed_q) begin
            count_d = count_dec;
            // The countdown expires on the tick that brings it to zero.
            if (count_dec == '0) begin
              armed_d = 1'b0;
              if (delay_q != PSF_NO_FIRE_US) begin
                if (delay_q > PSF_MAX_FIRE_US) delay_d = PSF_MAX_FIRE_US;
                pulse_d = pulse_width_i;
              end
            end
          end
        end
        PSF_MODE_ZC: begin
          count_d = delay_q;
          armed_d = 1'b1;
        end
        PSF_MODE_UPDATE: begin
          delay_d = new_delay_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= PSF_NO_FIRE_US;
      count_q <= '0;
      armed_q <= 1'b0;
      pulse_q <= '0;
    end else begin
      delay_q <= delay_d;
      count_q <= count_d;
      armed_q <= armed_d;
      pulse_q <= pulse_d;
    end
  end

  assign res_o.gate          = (pulse_q != '0);
  assign res_o.delay_us      = delay_q;
  assign res_o.timer_running = armed_q;

  a_delay_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (delay_q == PSF_NO_FIRE_US) || (delay_q <= PSF_MAX_FIRE_US))
    else $error("firing delay left the legal range");

  a_zc_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (mode_i == PSF_MODE_ZC)) |=> armed_q && (count_q == $past(delay_q)))
    else $error("zero crossing did not arm the countdown");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(delay_q) && $stable(count_q) && $stable(armed_q) && $stable(pulse_q))
    else $error("state changed without a step");

  a_update_keeps_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (mode_i == PSF_MODE_UPDATE)) |=> $stable(count_q) && $stable(armed_q))
    else $error("power update disturbed the countdown");

endmodule

FILE: src/phase_angle_scr_firing.sv
// Top level of the phase-angle thyristor firing controller.
// Depends on psf_pkg, the psf interfaces, psf_lookup and psf_state.
`timescale 1ns / 1ps

//  Channel  Modport  Word                                   Handshake
//  in_i     sink     mode, measured_power_dw                valid/ready
//  res_o    source   gate, delay_us, timer_running          valid/ready
//  cfg_i    sink     index, data (register write)           valid/ready, always ready
//
//  One word is accepted per cycle unless results stall; its result is set by the
//  input register followed by the state registers, which also hold the result word.
//  Reset loads the register defaults, a no-fire delay and an idle countdown.
//  A stalled result holds the state; the input register still takes one more word.

module phase_angle_scr_firing import psf_pkg::*; #(
  parameter int TableEntries = PSF_TABLE_ENTRIES
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  psf_in_if.sink    in_i,
  psf_out_if.source res_o,
  psf_cfg_if.sink   cfg_i
);

  psf_cfg_t               cfg_q;
  logic                   in_valid_q, in_valid_d;
  logic [PSF_MODE_W-1:0]  in_mode_q;
  logic [PSF_MEAS_W-1:0]  in_meas_q;
  logic                   out_valid_q, out_valid_d;
  logic                   advance;
  logic                   step;
  logic                   in_accept;
  logic [PSF_DELAY_W-1:0] new_delay;
  psf_res_t               res;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.control_mode       <= 1'b0;
      cfg_q.power_offset_w     <= '0;
      cfg_q.manual_power_w     <= '0;
      cfg_q.min_panel_power_dw <= PSF_MEAS_W'(500);
      cfg_q.pulse_width_us     <= PSF_PULSE_W'(30);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        PSF_CFG_CONTROL_MODE: cfg_q.control_mode       <= cfg_i.data[0];
        PSF_CFG_POWER_OFFSET: cfg_q.power_offset_w     <= cfg_i.data[PSF_WATTS_W-1:0];
        PSF_CFG_MANUAL_POWER: cfg_q.manual_power_w     <= cfg_i.data[PSF_WATTS_W-1:0];
        PSF_CFG_MIN_PANEL:    cfg_q.min_panel_power_dw <= cfg_i.data[PSF_MEAS_W-1:0];
        PSF_CFG_PULSE_WIDTH:  cfg_q.pulse_width_us     <= cfg_i.data[PSF_PULSE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The state advances only when the result slot is free or being emptied.
  assign advance     = !out_valid_q || res_o.ready;
  assign in_i.ready  = !in_valid_q || advance;
  assign in_accept   = in_i.valid && in_i.ready;
  assign step        = in_valid_q && advance;
  assign in_valid_d  = in_accept ? 1'b1 : (step ? 1'b0 : in_valid_q);
  assign out_valid_d = step ? 1'b1 : (res_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_mode_q <= in_i.mode;
      in_meas_q <= in_i.measured_power_dw;
    end
  end

  psf_lookup #(
    .TableEntries (TableEntries)
  ) u_lookup (
    .cfg_i   (cfg_q),
    .meas_i  (in_meas_q),
    .delay_o (new_delay)
  );

  psf_state u_state (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .mode_i        (in_mode_q),
    .new_delay_i   (new_delay),
    .pulse_width_i (cfg_q.pulse_width_us),
    .res_o         (res)
  );

  assign res_o.valid         = out_valid_q;
  assign res_o.gate          = res.gate;
  assign res_o.delay_us      = res.delay_us;
  assign res_o.timer_running = res.timer_running;

  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("processed word produced no result");

  a_stall_keeps_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q && $stable(in_mode_q) && $stable(in_meas_q))
    else $error("pending input word lost during a stall");

  a_no_step_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |-> !step)
    else $error("state advanced over an untaken result");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the phase-angle thyristor firing controller.
// Depends on psf_pkg, the psf interfaces and phase_angle_scr_firing; a predictor of
// the firing delay, countdown and gate pulse checks every result word in order.
`timescale 1ns / 1ps

module tb_top;
  import psf_pkg::*;

  localparam logic [PSF_MODE_W-1:0]    MODE_UNUSED   = 2'd3;
  localparam logic [PSF_CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
  localparam int MEAS_MAX     = (1 << PSF_MEAS_W) - 1;
  localparam int DRAIN_CYCLES = 4;

  // Result-side ready patterns.
  localparam int RX_ALWAYS   = 0;
  localparam int RX_RANDOM   = 1;
  localparam int RX_PERIODIC = 2;
  localparam int RX_BURSTY   = 3;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  psf_in_if  in_if ();
  psf_out_if res_if ();
  psf_cfg_if cfg_if ();

  phase_angle_scr_firing i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state and register copy.
  psf_cfg_t               regs_shadow;
  logic [PSF_DELAY_W-1:0] fire_delay;
  logic [PSF_DELAY_W-1:0] countdown_left;
  logic                   countdown_armed;
  logic [PSF_PULSE_W-1:0] pulse_left;
  psf_res_t               gate_words_q[$];

  int err_count      = 0;
  int words_sent     = 0;
  int reg_writes     = 0;
  int pulses_started = 0;
  int burst_left     = 0;
  bit gaps_on        = 1'b0;
  int stall_style    = RX_ALWAYS;
  int stall_cnt      = 0;
  int stall_hold     = 0;

  function automatic void reset_firing_state();
    regs_shadow = '{control_mode: 1'b0, power_offset_w: '0, manual_power_w: '0,
                    min_panel_power_dw: 18'd500, pulse_width_us: 10'd30};
    fire_delay      = PSF_NO_FIRE_US;
    countdown_left  = '0;
    countdown_armed = 1'b0;
    pulse_left      = '0;
  endfunction

  // First table entry at or above the request wins; past the end falls back to entry 0.
  function automatic logic [PSF_DELAY_W-1:0] delay_for_request(input int request_dw);
    for (int i = 0; i < PSF_TABLE_ENTRIES; i++) begin
      if (request_dw <= int'(PSF_WATTS[i]) * 10) return PSF_DELAYS[i];
    end
    return PSF_DELAYS[0];
  endfunction

  function automatic psf_res_t advance_firing(input logic [PSF_MODE_W-1:0] mode,
                                              input logic [PSF_MEAS_W-1:0] meas);
    psf_res_t word;
    case (mode)
      PSF_MODE_TICK: begin
        if (pulse_left != '0) pulse_left--;
        if (countdown_armed) begin
          if (countdown_left != '0) countdown_left--;
          if (countdown_left == '0) begin
            countdown_armed = 1'b0;
            if (fire_delay != PSF_NO_FIRE_US) begin
              if (fire_delay > PSF_MAX_FIRE_US) fire_delay = PSF_MAX_FIRE_US;
              pulse_left = regs_shadow.pulse_width_us;
              if (pulse_left != '0) pulses_started++;
            end
          end
        end
      end
      PSF_MODE_ZC: begin
        countdown_left  = fire_delay;
        countdown_armed = 1'b1;
      end
      PSF_MODE_UPDATE: begin
        if (!regs_shadow.control_mode) begin
          if (meas < regs_shadow.min_panel_power_dw) begin
            fire_delay = PSF_NO_FIRE_US;
          end else begin
            fire_delay = delay_for_request(int'($signed(regs_shadow.power_offset_w)) * 10
                                           + int'(meas));
          end
        end else if (regs_shadow.manual_power_w == '0) begin
          fire_delay = PSF_NO_FIRE_US;
        end else begin
          fire_delay = delay_for_request(int'(regs_shadow.manual_power_w) * 10);
        end
      end
      default: ;
    endcase
    word.gate          = (pulse_left != '0);
    word.delay_us      = fire_delay;
    word.timer_running = countdown_armed;
    return word;
  endfunction

  // With gaps on, the sender runs in random bursts, and valid may drop between them.
  task automatic send_word(input logic [PSF_MODE_W-1:0] mode,
                           input logic [PSF_MEAS_W-1:0] meas);
    int gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 15) == 0) gap = $urandom_range(6, 30);
        if (gap != 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
    in_if.valid             <= 1'b1;
    in_if.mode              <= mode;
    in_if.measured_power_dw <= meas;
    do @(posedge clk_i); while (!in_if.ready);
    gate_words_q.push_back(advance_firing(mode, meas));
    words_sent++;
  endtask

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    while (gate_words_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  // Leaves valid high so that back-to-back writes need no second assignment in one step.
  task automatic write_reg(input logic [PSF_CFG_IDX_W-1:0] idx,
                           input logic [PSF_CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    reg_writes++;
    case (idx)
      PSF_CFG_CONTROL_MODE: regs_shadow.control_mode       = value[0];
      PSF_CFG_POWER_OFFSET: regs_shadow.power_offset_w     = value[PSF_WATTS_W-1:0];
      PSF_CFG_MANUAL_POWER: regs_shadow.manual_power_w     = value[PSF_WATTS_W-1:0];
      PSF_CFG_MIN_PANEL:    regs_shadow.min_panel_power_dw = value;
      PSF_CFG_PULSE_WIDTH:  regs_shadow.pulse_width_us     = value[PSF_PULSE_W-1:0];
      default: ;
    endcase
  endtask

  // Must only be called with nothing in flight.
  task automatic program_regs(input int ctl, input int offset, input int manual,
                              input int min_dw, input int width);
    write_reg(PSF_CFG_CONTROL_MODE, 18'(ctl));
    write_reg(PSF_CFG_POWER_OFFSET, 18'(offset));
    write_reg(PSF_CFG_MANUAL_POWER, 18'(manual));
    write_reg(PSF_CFG_MIN_PANEL, 18'(min_dw));
    write_reg(PSF_CFG_PULSE_WIDTH, 18'(width));
    write_reg(CFG_IDX_SPARE, 18'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic pick_idling();
    gaps_on     = ($urandom_range(0, 3) != 0);
    stall_style = $urandom_range(RX_ALWAYS, RX_BURSTY);
  endtask

  // Mixes full-range values with ones on table edges and on the minimum-power edge.
  function automatic logic [PSF_MEAS_W-1:0] pick_measurement();
    int v;
    int jitter;
    jitter = $urandom_range(0, 2);
    jitter = jitter - 1;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, MEAS_MAX);
      1: v = int'(PSF_WATTS[$urandom_range(0, PSF_TABLE_SLOTS - 1)]) * 10 + jitter
             - int'($signed(regs_shadow.power_offset_w)) * 10;
      2: v = int'(regs_shadow.min_panel_power_dw) + jitter;
      default: v = $urandom_range(0, 1) ? MEAS_MAX : $urandom_range(0, 600);
    endcase
    if (v < 0) v = 0;
    if (v > MEAS_MAX) v = MEAS_MAX;
    return v[PSF_MEAS_W-1:0];
  endfunction

  task automatic send_random_word();
    case ($urandom_range(0, 9))
      0, 1, 2: send_word(PSF_MODE_UPDATE, pick_measurement());
      3, 4:    send_word(PSF_MODE_ZC, 18'($urandom));
      5, 6, 7, 8: send_word(PSF_MODE_TICK, 18'($urandom));
      default: send_word(MODE_UNUSED, 18'($urandom));
    endcase
  endtask

  // Update, zero crossing, ticks to expiry with some noise words, then tail ticks.
  task automatic fire_cycle(input logic [PSF_MEAS_W-1:0] meas, input bit noisy_updates,
                            input int tail_ticks);
    send_word(PSF_MODE_UPDATE, meas);
    send_word(PSF_MODE_ZC, 18'($urandom));
    while (countdown_armed) begin
      if ($urandom_range(0, 39) == 0) begin
        if (noisy_updates && $urandom_range(0, 1)) send_word(PSF_MODE_UPDATE, pick_measurement());
        else send_word(MODE_UNUSED, 18'($urandom));
      end else begin
        send_word(PSF_MODE_TICK, 18'($urandom));
      end
    end
    repeat (tail_ticks) send_word(PSF_MODE_TICK, 18'($urandom));
  endtask

  task automatic test_directed();
    gaps_on     = 1'b0;
    stall_style = RX_PERIODIC;
    send_word(PSF_MODE_TICK, 18'd0);
    send_word(MODE_UNUSED, 18'(MEAS_MAX));
    send_word(PSF_MODE_UPDATE, 18'd0);
    send_word(PSF_MODE_UPDATE, 18'd499);
    send_word(PSF_MODE_UPDATE, 18'd500);
    send_word(PSF_MODE_UPDATE, 18'd15000);
    send_word(PSF_MODE_UPDATE, 18'd15001);
    send_word(PSF_MODE_UPDATE, 18'(MEAS_MAX));
    send_word(PSF_MODE_ZC, 18'(MEAS_MAX));
    send_word(PSF_MODE_TICK, 18'(MEAS_MAX));
    send_word(PSF_MODE_ZC, 18'd0);
    // A no-fire update does not stop a running countdown.
    send_word(PSF_MODE_UPDATE, 18'd0);
    wait_for_results();
    // Most negative offset drives the request below zero.
    program_regs(0, -1024, 0, 0, 0);
    send_word(PSF_MODE_UPDATE, 18'd0);
    wait_for_results();
    program_regs(0, 1023, 2047, MEAS_MAX, 1023);
    send_word(PSF_MODE_UPDATE, 18'(MEAS_MAX - 1));
    send_word(PSF_MODE_UPDATE, 18'(MEAS_MAX));
    wait_for_results();
    // Upper data bits set on the mode register must be dropped.
    program_regs(MEAS_MAX, 0, 0, 500, 30);
    send_word(PSF_MODE_UPDATE, 18'($urandom));
    wait_for_results();
    program_regs(1, 0, 2047, 500, 30);
    send_word(PSF_MODE_UPDATE, 18'($urandom));
    wait_for_results();
    program_regs(1, 0, 1, 500, 30);
    send_word(PSF_MODE_UPDATE, 18'($urandom));
    wait_for_results();
    program_regs(1, 0, 1500, 500, 30);
    send_word(PSF_MODE_UPDATE, 18'($urandom));
    send_word(PSF_MODE_ZC, 18'($urandom));
    send_word(PSF_MODE_TICK, 18'($urandom));
    wait_for_results();
    program_regs(1, 0, 1450, 500, 30);
    send_word(PSF_MODE_UPDATE, 18'($urandom));
  endtask

  task automatic test_random_mix();
    for (int round = 0; round < 3; round++) begin
      wait_for_results();
      pick_idling();
      case (round)
        0: program_regs(0, -1000, $urandom_range(0, 1500), 0, $urandom_range(1, 1000));
        1: program_regs(0, 1000, 0, MEAS_MAX, 1000);
        default: program_regs($urandom, $urandom, $urandom, $urandom_range(0, 2000), $urandom);
      endcase
      repeat (100) send_random_word();
    end
  endtask

  task automatic test_manual_no_pulse();
    wait_for_results();
    gaps_on     = 1'b1;
    stall_style = RX_BURSTY;
    program_regs(1, 0, 1500, 500, 0);
    fire_cycle(18'($urandom), 1'b1, 20);
  endtask

  task automatic test_auto_single_tick_pulse();
    int offset;
    int meas;
    wait_for_results();
    gaps_on     = 1'b1;
    stall_style = RX_RANDOM;
    offset = $urandom_range(0, 200);
    offset = offset - 100;
    program_regs(0, offset, 0, 0, 1);
    // Request lands on the last table entry, which gives the shortest delay.
    meas = $urandom_range(14501, 15000);
    meas = meas - offset * 10;
    fire_cycle(18'(meas), 1'b0, 10);
  endtask

  task automatic test_pulse_overlap();
    wait_for_results();
    gaps_on     = 1'b0;
    stall_style = RX_ALWAYS;
    program_regs(1, 0, 1500, 500, 1023);
    fire_cycle(18'($urandom), 1'b1, 0);
    gaps_on     = 1'b1;
    stall_style = RX_PERIODIC;
    repeat (100) send_word(PSF_MODE_TICK, 18'($urandom));
    // Hold off mid-pulse until every result word is back.
    wait_for_results();
    // The next expiry falls inside the long pulse and restarts its length.
    fire_cycle(18'($urandom), 1'b1, 40);
  endtask

  // Result-side ready.
  always @(posedge clk_i) begin
    stall_cnt = stall_cnt + 1;
    case (stall_style)
      RX_ALWAYS:   res_if.ready <= 1'b1;
      RX_RANDOM:   res_if.ready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: res_if.ready <= ((stall_cnt % 7) < 4);
      default: begin
        if (stall_hold != 0) begin
          stall_hold = stall_hold - 1;
          res_if.ready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          stall_hold = $urandom_range(4, 12);
          res_if.ready <= 1'b0;
        end else begin
          res_if.ready <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk_i) begin : check_results
    psf_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (gate_words_q.size() == 0) begin
        $error("result word with no expected word pending");
        err_count++;
      end else begin
        want = gate_words_q.pop_front();
        if (res_if.gate !== want.gate) begin
          $error("gate: expected %0d, got %0d", want.gate, res_if.gate);
          err_count++;
        end
        if (res_if.delay_us !== want.delay_us) begin
          $error("delay_us: expected %0d, got %0d", want.delay_us, res_if.delay_us);
          err_count++;
        end
        if (res_if.timer_running !== want.timer_running) begin
          $error("timer_running: expected %0d, got %0d", want.timer_running,
                 res_if.timer_running);
          err_count++;
        end
      end
    end
  end

  initial begin
    in_if.valid             <= 1'b0;
    in_if.mode              <= PSF_MODE_TICK;
    in_if.measured_power_dw <= '0;
    cfg_if.valid            <= 1'b0;
    cfg_if.index            <= PSF_CFG_CONTROL_MODE;
    cfg_if.data             <= '0;
    reset_firing_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_mix();
    test_manual_no_pulse();
    test_auto_single_tick_pulse();
    test_pulse_overlap();
    wait_for_results();

    $display("Sent %0d words and %0d register writes: ticks, zero crossings, updates and the",
             words_sent, reg_writes);
    $display("spare step code in both control modes; %0d gate pulses were started.",
             pulses_started);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: sim.f
src/psf_pkg.sv
src/psf_if.sv
src/psf_lookup.sv
src/psf_state.sv
src/phase_angle_scr_firing.sv
dv/tb_top.sv
